/* rtl/fplw_pkg.sv */
// ----------------------------------------------------------------------------
// fplw_pkg: shared types and codes of the four-level page walker
// Item layouts, walk level codes, status and kind codes used by the walker.
// ----------------------------------------------------------------------------
package fplw_pkg;

   // Operation code of an input item.
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_RESPONSE  = 1'b1;

   // Kind code of a result item.
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Walk status codes.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_READ_FAIL   = 2'd1;
   localparam logic [1:0] STATUS_NOT_PRESENT = 2'd2;

   // Walk level codes: idle, or the table whose entry is awaited.
   localparam logic [2:0] LVL_IDLE = 3'd0;
   localparam logic [2:0] LVL_PML4 = 3'd1;
   localparam logic [2:0] LVL_PDPT = 3'd2;
   localparam logic [2:0] LVL_PD   = 3'd3;
   localparam logic [2:0] LVL_PT   = 3'd4;

   typedef struct packed {
      logic        op;
      logic [63:0] root_table;
      logic [47:0] virt_addr;
      logic [47:0] slot_base;
      logic [63:0] entry_data;
      logic        read_ok;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [51:0] read_addr;
      logic [1:0]  status;
      logic [51:0] phys_addr;
      logic [39:0] frame_number;
      logic [47:0] mapped_virt;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  level;
      logic [47:0] held_virt;
      logic [47:0] held_slot_base;
   } walk_state_type;

endpackage

/* rtl/fplw_if.sv */
// ----------------------------------------------------------------------------
// fplw_if: channel interfaces of the four-level page walker
// Request channel (translate requests and memory responses) and result channel.
// ----------------------------------------------------------------------------
interface fplw_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] root_table;
   logic [47:0] virt_addr;
   logic [47:0] slot_base;
   logic [63:0] entry_data;
   logic        read_ok;

   modport source (output valid, op, root_table, virt_addr, slot_base, entry_data,
                   read_ok, input ready);
   modport sink   (input valid, op, root_table, virt_addr, slot_base, entry_data,
                   read_ok, output ready);
endinterface

interface fplw_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [51:0] read_addr;
   logic [1:0]  status;
   logic [51:0] phys_addr;
   logic [39:0] frame_number;
   logic [47:0] mapped_virt;

   modport source (output valid, kind, read_addr, status, phys_addr, frame_number,
                   mapped_virt, input ready);
   modport sink   (input valid, kind, read_addr, status, phys_addr, frame_number,
                   mapped_virt, output ready);
endinterface

/* rtl/fplw_step.sv */
// ----------------------------------------------------------------------------
// fplw_step: one walk step
// Given the walk state and one input item, forms the next state and the
// result item, if the item causes one.
// ----------------------------------------------------------------------------
module fplw_step
   import fplw_pkg::*;
(
   input  walk_state_type state_cur,
   input  req_item_type   item,
   output walk_state_type state_nxt,
   output logic           has_result,
   output rsp_item_type   result
);

   logic [2:0]  idx_level;
   logic [47:0] idx_virt;
   logic [8:0]  index;
   logic [11:0] page_off;

   // Level whose index selects the next entry to read.
   always_comb begin
      if (item.op == OP_TRANSLATE) begin
         idx_level = LVL_PML4;
         idx_virt  = item.virt_addr;
      end else begin
         idx_level = state_cur.level + 3'd1;
         idx_virt  = state_cur.held_virt;
      end
   end

   always_comb begin
      unique case (idx_level)
         LVL_PML4: index = idx_virt[47:39];
         LVL_PDPT: index = idx_virt[38:30];
         LVL_PD:   index = idx_virt[29:21];
         LVL_PT:   index = idx_virt[20:12];
         default:  index = '0;
      endcase
   end

   assign page_off = state_cur.held_virt[11:0];

   always_comb begin
      state_nxt  = state_cur;
      has_result = 1'b0;
      result     = '0;
      if (item.op == OP_TRANSLATE) begin
         state_nxt.level          = LVL_PML4;
         state_nxt.held_virt      = item.virt_addr;
         state_nxt.held_slot_base = item.slot_base;
         has_result               = 1'b1;
         result.kind              = KIND_READ;
         result.read_addr         = {item.root_table[51:12], index, 3'b000};
      end else if (state_cur.level == LVL_IDLE || state_cur.level > LVL_PT) begin
         // A response with no walk in progress is dropped.
         state_nxt.level = LVL_IDLE;
      end else begin
         has_result = 1'b1;
         if (!item.read_ok) begin
            state_nxt.level = LVL_IDLE;
            result.kind     = KIND_DONE;
            result.status   = STATUS_READ_FAIL;
         end else if (!item.entry_data[0]) begin
            state_nxt.level = LVL_IDLE;
            result.kind     = KIND_DONE;
            result.status   = STATUS_NOT_PRESENT;
         end else if (state_cur.level != LVL_PT) begin
            state_nxt.level  = idx_level;
            result.kind      = KIND_READ;
            result.read_addr = {item.entry_data[51:12], index, 3'b000};
         end else begin
            state_nxt.level     = LVL_IDLE;
            result.kind         = KIND_DONE;
            result.status       = STATUS_OK;
            result.phys_addr    = {item.entry_data[51:12], page_off};
            result.frame_number = item.entry_data[51:12];
            result.mapped_virt  = state_cur.held_slot_base + {36'd0, page_off};
         end
      end
   end

endmodule

/* rtl/four_level_page_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_walker: x86-64 four-level page table walker, 4 KiB pages
// Takes translate requests and memory read responses, issues entry reads for
// the PML4, PDPT, PD and PT levels and reports the finished translation.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Carries
//   req_chan   in         translate requests and memory read responses
//   rsp_chan   out        memory read requests and walk-finished reports
//
// Every item is registered on entry and worked on once the result register has
// room; the result it causes is registered in turn and offered on rsp_chan.
// One item is accepted per cycle while the result register is not stalled.
// Reset is synchronous and active high; it idles the walk and empties both registers.
// When the result register is full and not being taken, the input register
// holds its item and req_chan.ready drops until space opens up.
// ----------------------------------------------------------------------------
module four_level_page_walker
   import fplw_pkg::*;
(
   input logic         clock,
   input logic         reset,
   fplw_req_if.sink    req_chan,
   fplw_rsp_if.source  rsp_chan
);

   // Input register: holds the accepted item until the step logic takes it.
   req_item_type   req_item_ff;
   logic           req_valid_ff;

   // Walk state carried from one item to the next.
   walk_state_type state_ff;
   walk_state_type state_in;

   // Result register toward the output channel.
   rsp_item_type   rsp_item_ff;
   logic           rsp_valid_ff;

   logic           step_has_result;
   rsp_item_type   step_result;
   logic           out_free;
   logic           step_go;
   logic           req_take;

   fplw_step u_step (
      .state_cur  (state_ff),
      .item       (req_item_ff),
      .state_nxt  (state_in),
      .has_result (step_has_result),
      .result     (step_result)
   );

   // The result register can take a new item when it is empty or being read.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // The held item is processed once there is room for whatever it produces.
   assign step_go  = req_valid_ff && out_free;
   assign req_chan.ready = !req_valid_ff || step_go;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (step_go) begin
            req_valid_ff <= 1'b0;
         end
         if (step_go) begin
            state_ff     <= state_in;
            rsp_valid_ff <= step_has_result;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.op         <= req_chan.op;
         req_item_ff.root_table <= req_chan.root_table;
         req_item_ff.virt_addr  <= req_chan.virt_addr;
         req_item_ff.slot_base  <= req_chan.slot_base;
         req_item_ff.entry_data <= req_chan.entry_data;
         req_item_ff.read_ok    <= req_chan.read_ok;
      end
      if (step_go && step_has_result) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_item_ff.kind;
   assign rsp_chan.read_addr    = rsp_item_ff.read_addr;
   assign rsp_chan.status       = rsp_item_ff.status;
   assign rsp_chan.phys_addr    = rsp_item_ff.phys_addr;
   assign rsp_chan.frame_number = rsp_item_ff.frame_number;
   assign rsp_chan.mapped_virt  = rsp_item_ff.mapped_virt;

endmodule
